FILE: rtl/core/gd3tfe_pkg.sv
// ----------------------------------------------------------------------------
// gd3tfe_pkg
// shared types, codes and helpers of the tag field extractor
// ----------------------------------------------------------------------------
package gd3tfe_pkg;

    localparam int FIELD_W            = 4;
    localparam int DEFAULT_NUM_FIELDS = 11;
    localparam int DEFAULT_Q_DEPTH    = 4;

    typedef enum logic [1:0] {
        KIND_TEXT      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_HEADER    = 2'd2,
        KIND_FINISH    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_PTR   = 3'd2,
        ST_CUT   = 3'd3,
        ST_MAGIC = 3'd4
    } t_status;

    localparam logic [32:0] TAG_OFFSET  = 33'h14;
    localparam logic [30:0] PTR_WORD    = 31'd5;
    localparam logic [3:0]  CHUNK_LAST  = 4'd11;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;

    // results caused by one input transaction, in output order:
    // header, text bytes, field ends, finish
    typedef struct packed {
        logic                has_hdr;
        logic [31:0]         ver;
        logic [31:0]         len;
        logic [1:0]          txt_n;
        logic [15:0]         unit;
        logic [FIELD_W-1:0]  field;
        logic [FIELD_W-1:0]  fe_count;
        logic                has_fin;
        t_status             status;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [1:0] k);
        logic [7:0] m;
        case (k)
            2'd0:    m = 8'h47;
            2'd1:    m = 8'h64;
            2'd2:    m = 8'h33;
            default: m = 8'h20;
        endcase
        return m;
    endfunction

    // rem counts down from tot to 1
    function automatic logic [7:0] utf8_byte(input logic [15:0] unit,
                                             input logic [1:0] tot,
                                             input logic [1:0] rem);
        logic [7:0] b;
        case (rem)
            2'd3: b = UTF8_LEAD3 | {4'b0, unit[15:12]};
            2'd2: begin
                if (tot == 2'd3) begin
                    b = UTF8_CONT | {2'b0, unit[11:6]};
                end else begin
                    b = UTF8_LEAD2 | {3'b0, unit[10:6]};
                end
            end
            default: begin
                if (tot == 2'd1) begin
                    b = unit[7:0];
                end else begin
                    b = UTF8_CONT | {2'b0, unit[5:0]};
                end
            end
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/gd3tfe_front.sv
// ----------------------------------------------------------------------------
// gd3tfe_front
// byte parser: tracks the file layout and issues at most one command per transaction
// ----------------------------------------------------------------------------
module gd3tfe_front #(
    parameter int NUM_FIELDS = gd3tfe_pkg::DEFAULT_NUM_FIELDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_file_byte,
    input  logic              i_end_of_file,
    output logic              o_q_push,
    output gd3tfe_pkg::t_cmd  o_cmd
);
    import gd3tfe_pkg::*;

    localparam logic [FIELD_W-1:0] NF = FIELD_W'(NUM_FIELDS);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SEEK   = 5'b00010,
        PH_CHUNK  = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [32:0]        r_pos, n_pos;
    logic [32:0]        r_target, n_target;
    logic [31:0]        r_ptr, n_ptr;
    logic [31:0]        r_ver, n_ver;
    logic [31:0]        r_len, n_len;
    logic [31:0]        r_left, n_left;
    logic [7:0]         r_low, n_low;
    logic               r_have, n_have;
    logic [FIELD_W-1:0] r_field, n_field;
    logic               r_magic, n_magic;
    logic [3:0]         r_k, n_k;

    t_cmd               cmd;
    logic               chunk_now;
    logic [3:0]         k;
    logic [15:0]        unit;
    logic [FIELD_W-1:0] field_inc;
    logic [31:0]        ptr_full;
    logic [31:0]        len_full;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_target = r_target;
        n_ptr    = r_ptr;
        n_ver    = r_ver;
        n_len    = r_len;
        n_left   = r_left;
        n_low    = r_low;
        n_have   = r_have;
        n_field  = r_field;
        n_magic  = r_magic;
        n_k      = r_k;
        cmd      = '0;
        cmd.status = ST_OK;

        chunk_now = (r_phase == PH_CHUNK) || ((r_phase == PH_SEEK) && (r_pos == r_target));
        k         = (r_phase == PH_CHUNK) ? r_k : 4'd0;
        unit      = {i_file_byte, r_low};
        field_inc = r_field + 1'b1;
        ptr_full  = {i_file_byte, r_ptr[23:0]};
        len_full  = {i_file_byte, r_len[23:0]};

        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos[32:2] == PTR_WORD) begin
                        case (r_pos[1:0])
                            2'd0:    n_ptr[7:0]   = i_file_byte;
                            2'd1:    n_ptr[15:8]  = i_file_byte;
                            2'd2:    n_ptr[23:16] = i_file_byte;
                            default: n_ptr[31:24] = i_file_byte;
                        endcase
                        if (r_pos[1:0] == 2'd3) begin
                            n_target = {1'b0, ptr_full} + TAG_OFFSET;
                            if (ptr_full[31:2] == 30'd0) begin
                                cmd.has_fin = 1'b1;
                                cmd.status  = ST_PTR;
                                n_phase     = PH_DONE;
                            end else begin
                                n_phase = PH_SEEK;
                            end
                        end
                    end
                end
                PH_SEEK, PH_CHUNK: begin
                    if (chunk_now) begin
                        n_phase = PH_CHUNK;
                        n_k     = k + 4'd1;
                        if (k < 4'd4) begin
                            if (i_file_byte != magic_byte(k[1:0])) begin
                                n_magic = 1'b0;
                            end
                        end else if (k < 4'd8) begin
                            case (k[1:0])
                                2'd0:    n_ver[7:0]   = i_file_byte;
                                2'd1:    n_ver[15:8]  = i_file_byte;
                                2'd2:    n_ver[23:16] = i_file_byte;
                                default: n_ver[31:24] = i_file_byte;
                            endcase
                        end else begin
                            case (k[1:0])
                                2'd0:    n_len[7:0]   = i_file_byte;
                                2'd1:    n_len[15:8]  = i_file_byte;
                                2'd2:    n_len[23:16] = i_file_byte;
                                default: n_len[31:24] = i_file_byte;
                            endcase
                        end
                        if (k == CHUNK_LAST) begin
                            if (!r_magic) begin
                                cmd.has_fin = 1'b1;
                                cmd.status  = ST_MAGIC;
                                n_phase     = PH_DONE;
                            end else begin
                                cmd.has_hdr = 1'b1;
                                cmd.ver     = r_ver;
                                cmd.len     = len_full;
                                n_left      = len_full;
                                n_field     = '0;
                                n_phase     = PH_DATA;
                                if (len_full == 32'd0) begin
                                    cmd.field    = '0;
                                    cmd.fe_count = NF;
                                    cmd.has_fin  = 1'b1;
                                    n_phase      = PH_DONE;
                                end
                            end
                        end
                    end
                end
                PH_DATA: begin
                    n_left    = r_left - 32'd1;
                    cmd.field = r_field;
                    if (!r_have) begin
                        n_low  = i_file_byte;
                        n_have = 1'b1;
                    end else begin
                        n_have = 1'b0;
                        if (unit == 16'd0) begin
                            cmd.fe_count = {{(FIELD_W-1){1'b0}}, 1'b1};
                            n_field      = field_inc;
                        end else begin
                            cmd.unit = unit;
                            if (unit[15:7] == 9'd0) begin
                                cmd.txt_n = 2'd1;
                            end else if (unit[15:11] == 5'd0) begin
                                cmd.txt_n = 2'd2;
                            end else begin
                                cmd.txt_n = 2'd3;
                            end
                        end
                    end
                    if (r_have && (unit == 16'd0) && (field_inc == NF)) begin
                        cmd.has_fin = 1'b1;
                        n_phase     = PH_DONE;
                    end else if (r_left == 32'd1) begin
                        cmd.fe_count = NF - r_field;
                        cmd.has_fin  = 1'b1;
                        n_phase      = PH_DONE;
                    end
                end
                default: ;
            endcase

            if (r_pos != {33{1'b1}}) begin
                n_pos = r_pos + 33'd1;
            end

            if (i_end_of_file) begin
                case (n_phase)
                    PH_HEADER: begin
                        cmd.has_fin = 1'b1;
                        cmd.status  = ST_SHORT;
                    end
                    PH_SEEK, PH_CHUNK: begin
                        cmd.has_fin = 1'b1;
                        cmd.status  = ST_CUT;
                    end
                    PH_DATA: begin
                        if (cmd.fe_count == '0) begin
                            cmd.field = n_field;
                        end
                        cmd.fe_count = NF - cmd.field;
                        cmd.has_fin  = 1'b1;
                    end
                    default: ;
                endcase
                n_phase  = PH_HEADER;
                n_pos    = '0;
                n_target = '0;
                n_ptr    = '0;
                n_ver    = '0;
                n_len    = '0;
                n_left   = '0;
                n_low    = '0;
                n_have   = 1'b0;
                n_field  = '0;
                n_magic  = 1'b1;
                n_k      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_target <= '0;
            r_ptr    <= '0;
            r_ver    <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_low    <= '0;
            r_have   <= 1'b0;
            r_field  <= '0;
            r_magic  <= 1'b1;
            r_k      <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_target <= n_target;
            r_ptr    <= n_ptr;
            r_ver    <= n_ver;
            r_len    <= n_len;
            r_left   <= n_left;
            r_low    <= n_low;
            r_have   <= n_have;
            r_field  <= n_field;
            r_magic  <= n_magic;
            r_k      <= n_k;
        end
    end

    assign o_cmd    = cmd;
    assign o_q_push = i_accept && (cmd.has_hdr || (cmd.txt_n != 2'd0)
                                   || (cmd.fe_count != '0) || cmd.has_fin);

endmodule

FILE: rtl/core/gd3tfe_queue.sv
// ----------------------------------------------------------------------------
// gd3tfe_queue
// small command fifo between parser and result sequencer
// ----------------------------------------------------------------------------
module gd3tfe_queue #(
    parameter int DEPTH = gd3tfe_pkg::DEFAULT_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gd3tfe_pkg::t_cmd  i_cmd,
    input  logic              i_pop,
    output gd3tfe_pkg::t_cmd  o_cmd,
    output logic              o_valid,
    output logic              o_full
);
    import gd3tfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_cnt != FULL_CNT);
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);

endmodule

FILE: rtl/core/gd3tfe_back.sv
// ----------------------------------------------------------------------------
// gd3tfe_back
// result sequencer: expands commands into result transactions; while results are popped, one per cycle
// ----------------------------------------------------------------------------
module gd3tfe_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gd3tfe_pkg::t_cmd                  i_cmd,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output gd3tfe_pkg::t_kind                 o_kind,
    output logic [gd3tfe_pkg::FIELD_W-1:0]    o_field_index,
    output logic [7:0]                        o_text_byte,
    output logic [31:0]                       o_tag_version,
    output logic [31:0]                       o_data_length,
    output gd3tfe_pkg::t_status               o_status,
    output logic                              o_run_last
);
    import gd3tfe_pkg::*;

    // working command
    logic               r_hdr;
    logic [1:0]         r_txt_n;
    logic [FIELD_W-1:0] r_fe_cnt;
    logic               r_fin;
    logic [31:0]        r_ver;
    logic [31:0]        r_len;
    logic [1:0]         r_txt_tot;
    logic [15:0]        r_unit;
    logic [FIELD_W-1:0] r_field;
    t_status            r_status;

    // output register
    logic               r_o_valid;
    t_kind              r_o_kind;
    logic [FIELD_W-1:0] r_o_field;
    logic [7:0]         r_o_text;
    logic [31:0]        r_o_ver;
    logic [31:0]        r_o_len;
    t_status            r_o_status;
    logic               r_o_last;

    logic               busy, adv, emit, load;
    t_kind              it_kind;
    logic [FIELD_W-1:0] it_field;
    logic [7:0]         it_text;
    logic [31:0]        it_ver;
    logic [31:0]        it_len;
    t_status            it_status;
    logic               it_last;

    assign busy = r_hdr || (r_txt_n != 2'd0) || (r_fe_cnt != '0) || r_fin;

    always_comb begin
        it_kind   = KIND_FINISH;
        it_field  = '0;
        it_text   = '0;
        it_ver    = '0;
        it_len    = '0;
        it_status = ST_OK;
        it_last   = 1'b1;
        if (r_hdr) begin
            it_kind = KIND_HEADER;
            it_ver  = r_ver;
            it_len  = r_len;
            it_last = (r_txt_n == 2'd0) && (r_fe_cnt == '0) && !r_fin;
        end else if (r_txt_n != 2'd0) begin
            it_kind  = KIND_TEXT;
            it_field = r_field;
            it_text  = utf8_byte(r_unit, r_txt_tot, r_txt_n);
            it_last  = (r_txt_n == 2'd1) && (r_fe_cnt == '0) && !r_fin;
        end else if (r_fe_cnt != '0) begin
            it_kind  = KIND_FIELD_END;
            it_field = r_field;
            it_last  = (r_fe_cnt == {{(FIELD_W-1){1'b0}}, 1'b1}) && !r_fin;
        end else begin
            it_status = r_status;
        end
    end

    assign adv  = !r_o_valid || i_pop;
    assign emit = adv && busy;
    assign load = i_cmd_valid && (!busy || (emit && it_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr     <= 1'b0;
            r_txt_n   <= '0;
            r_fe_cnt  <= '0;
            r_fin     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_o_valid <= busy;
            end
            if (load) begin
                r_hdr    <= i_cmd.has_hdr;
                r_txt_n  <= i_cmd.txt_n;
                r_fe_cnt <= i_cmd.fe_count;
                r_fin    <= i_cmd.has_fin;
            end else if (emit) begin
                if (r_hdr) begin
                    r_hdr <= 1'b0;
                end else if (r_txt_n != 2'd0) begin
                    r_txt_n <= r_txt_n - 2'd1;
                end else if (r_fe_cnt != '0) begin
                    r_fe_cnt <= r_fe_cnt - 1'b1;
                end else begin
                    r_fin <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ver     <= i_cmd.ver;
            r_len     <= i_cmd.len;
            r_txt_tot <= i_cmd.txt_n;
            r_unit    <= i_cmd.unit;
            r_field   <= i_cmd.field;
            r_status  <= i_cmd.status;
        end else if (emit && !r_hdr && (r_txt_n == 2'd0) && (r_fe_cnt != '0)) begin
            r_field <= r_field + 1'b1;
        end
        if (emit) begin
            r_o_kind   <= it_kind;
            r_o_field  <= it_field;
            r_o_text   <= it_text;
            r_o_ver    <= it_ver;
            r_o_len    <= it_len;
            r_o_status <= it_status;
            r_o_last   <= it_last;
        end
    end

    assign o_cmd_pop     = load;
    assign o_empty       = !r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_field_index = r_o_field;
    assign o_text_byte   = r_o_text;
    assign o_tag_version = r_o_ver;
    assign o_data_length = r_o_len;
    assign o_status      = r_o_status;
    assign o_run_last    = r_o_last;

endmodule

FILE: rtl/core/gd3_tag_field_extractor.sv
// ----------------------------------------------------------------------------
// gd3_tag_field_extractor
// Reads a VGM file one byte per transaction and returns its tag chunk as
// results: a header item with version and data length, the UTF-8 bytes of
// each UTF-16LE tag field with a field-end after each, and one finishing item
// with a status. A byte is accepted in every cycle in which the command queue
// (QUEUE_DEPTH entries) has room. The result sequencer delivers one result
// per cycle from its output register while results are popped, so a byte
// that causes several results holds the back end until all are delivered:
// a code unit of two bytes gives one to three text bytes, and a byte that
// ends the region or the file can cause up to three text bytes, a field end
// for every field and the finishing item. Results of earlier bytes drain
// while later bytes are parsed.
// ----------------------------------------------------------------------------
module gd3_tag_field_extractor #(
    parameter int NUM_FIELDS  = gd3tfe_pkg::DEFAULT_NUM_FIELDS,
    parameter int QUEUE_DEPTH = gd3tfe_pkg::DEFAULT_Q_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_file_byte,
    input  logic                            i_end_of_file,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_kind,
    output logic [gd3tfe_pkg::FIELD_W-1:0]  o_field_index,
    output logic [7:0]                      o_text_byte,
    output logic [31:0]                     o_tag_version,
    output logic [31:0]                     o_data_length,
    output logic [2:0]                      o_status,
    output logic                            o_run_last
);
    import gd3tfe_pkg::*;

    logic    w_accept;
    logic    w_q_push;
    logic    w_q_pop;
    logic    w_q_valid;
    logic    w_q_full;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_kind   w_kind;
    t_status w_status;

    assign w_accept = push && !w_q_full;
    assign full     = w_q_full;

    gd3tfe_front #(
        .NUM_FIELDS (NUM_FIELDS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .o_q_push      (w_q_push),
        .o_cmd         (w_cmd_in)
    );

    gd3tfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_q_pop),
        .o_cmd   (w_cmd_out),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    gd3tfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd_out),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_pop     (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (w_kind),
        .o_field_index (o_field_index),
        .o_text_byte   (o_text_byte),
        .o_tag_version (o_tag_version),
        .o_data_length (o_data_length),
        .o_status      (w_status),
        .o_run_last    (o_run_last)
    );

    assign o_kind   = w_kind;
    assign o_status = w_status;

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("command pushed into full queue");

    a_finish_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (w_kind == KIND_FINISH)) |-> o_run_last)
        else $error("finish item not last of its transaction");

    a_field_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((w_kind == KIND_TEXT) || (w_kind == KIND_FIELD_END)))
        |-> (o_field_index < FIELD_W'(NUM_FIELDS)))
        else $error("field index out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("command taken from empty queue");
`endif

endmodule
